@@ design/aes_pkg.sv @@
// Package with shared types, S-box tables and round functions for the AES block cipher.
package aes_pkg;

    localparam int NUM_ROWS = 15;    // round-key rows, one 128-bit row per round key
    localparam int ROW_AW   = 4;     // round-key row address width

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FETCH,
        ST_ROUND,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INIT,
        OP_MID,
        OP_LAST
    } t_op;

    typedef struct packed {
        logic cfg_wr;
        logic start;
    } t_kx_cmd;

    typedef struct packed {
        logic       hit;
        logic       busy;
        logic       done;
        logic [1:0] key_size;
    } t_kx_stat;

    typedef struct packed {
        logic load;
        t_op  op;
        logic dec;
        logic out_load;
    } t_dp_cmd;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [3:0] num_rounds(input logic [1:0] ks);
        num_rounds = 4'd10 + {1'b0, ks, 1'b0};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]],
                    FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

    // Byte k of the state sits at bits [127-8k -: 8].
    function automatic logic [127:0] fwd_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] =
                    FWD_SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        fwd_sub_shift = t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] =
                    INV_SBOX[s[127 - 8 * (4 * c + r) -: 8]];
            end
        end
        inv_sub_shift = t;
    endfunction

    function automatic logic [127:0] fwd_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            t[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            t[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        fwd_mix = t;
    endfunction

    // Multiples 9, 11, 13 and 14 of each byte built from doubling chains.
    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a [4];
        logic [7:0]   m9 [4];
        logic [7:0]   m11 [4];
        logic [7:0]   m13 [4];
        logic [7:0]   m14 [4];
        logic [7:0]   x2, x4, x8;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]   = s[127 - 8 * (4 * c + r) -: 8];
                x2     = xt(a[r]);
                x4     = xt(x2);
                x8     = xt(x4);
                m9[r]  = x8 ^ a[r];
                m11[r] = x8 ^ x2 ^ a[r];
                m13[r] = x8 ^ x4 ^ a[r];
                m14[r] = x8 ^ x4 ^ x2;
            end
            t[127 - 32 * c -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            t[119 - 32 * c -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            t[111 - 32 * c -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            t[103 - 32 * c -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        inv_mix = t;
    endfunction

endpackage

@@ design/aes_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/aes_keyexp.sv @@
// Key registers and word-serial key-schedule expansion into the round-key RAM.
module aes_keyexp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  aes_pkg::t_kx_cmd              i_cmd,
    input  logic [2:0]                    i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    output aes_pkg::t_kx_stat             o_stat,
    output logic                          o_we,
    output logic [aes_pkg::ROW_AW-1:0]    o_waddr,
    output logic [127:0]                  o_wdata
);

    logic [1:0]  r_ks;
    logic [63:0] r_key [4];
    logic [31:0] r_win [8];
    logic [95:0] r_row;
    logic [5:0]  r_i;
    logic [2:0]  r_j;
    logic        r_first;
    logic [7:0]  r_rc;
    logic        r_busy;

    logic [2:0]  nk_m1;
    logic [5:0]  last_i;
    logic [63:0] kw;
    logic [31:0] prev;
    logic [31:0] t;
    logic [31:0] new_word;
    logic        hit;
    logic        done;

    always_comb begin
        nk_m1  = 3'd3 + {r_ks, 1'b0};
        last_i = {aes_pkg::num_rounds(r_ks), 2'b11};
        kw     = r_key[r_i[2:1]];
        prev   = r_win[0];
        if (r_j == 3'd0) begin
            t = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {r_rc, 24'd0};
        end else if (r_ks == aes_pkg::KS_256 && r_j == 3'd4) begin
            t = aes_pkg::sub_word(prev);
        end else begin
            t = prev;
        end
        if (r_first) begin
            new_word = r_i[0] ? kw[31:0] : kw[63:32];
        end else begin
            new_word = r_win[nk_m1] ^ t;
        end
        hit = (i_cfg_index == aes_pkg::REG_KEY_SIZE && i_cfg_data <= 64'd2) ||
              (i_cfg_index >= aes_pkg::REG_KEY_W0 && i_cfg_index <= aes_pkg::REG_KEY_W3);
        done = r_busy && r_i == last_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks    <= aes_pkg::KS_128;
            r_busy  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_first <= 1'b1;
            r_rc    <= 8'h01;
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
        end else begin
            if (i_cmd.cfg_wr && hit) begin
                if (i_cfg_index == aes_pkg::REG_KEY_SIZE) begin
                    r_ks <= i_cfg_data[1:0];
                end else begin
                    r_key[2'(i_cfg_index - aes_pkg::REG_KEY_W0)] <= i_cfg_data;
                end
            end
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_i     <= '0;
                r_j     <= '0;
                r_first <= 1'b1;
                r_rc    <= 8'h01;
            end else if (r_busy) begin
                r_i <= r_i + 6'd1;
                if (r_j == nk_m1) begin
                    r_j     <= '0;
                    r_first <= 1'b0;
                end else begin
                    r_j <= r_j + 3'd1;
                end
                if (!r_first && r_j == 3'd0) begin
                    r_rc <= aes_pkg::xt(r_rc);
                end
                if (done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The window holds the last eight schedule words, newest first.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_win[0] <= new_word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k - 1];
            end
            r_row <= {r_row[63:0], new_word};
        end
    end

    assign o_we          = r_busy && r_i[1:0] == 2'b11;
    assign o_waddr       = r_i[5:2];
    assign o_wdata       = {r_row, new_word};
    assign o_stat.hit    = hit;
    assign o_stat.busy   = r_busy;
    assign o_stat.done   = done;
    assign o_stat.key_size = r_ks;

endmodule

@@ design/aes_datapath.sv @@
// Round-iterative AES state datapath with the result register.
module aes_datapath (
    input  logic              i_clk,
    input  aes_pkg::t_dp_cmd  i_cmd,
    input  logic [63:0]       i_block_hi,
    input  logic [63:0]       i_block_lo,
    input  logic [127:0]      i_rk,
    output logic [63:0]       o_result_hi,
    output logic [63:0]       o_result_lo
);

    logic [127:0] r_s;
    logic [127:0] n_s;
    logic [127:0] r_res;
    logic [127:0] fs;
    logic [127:0] is;

    always_comb begin
        fs = aes_pkg::fwd_sub_shift(r_s);
        is = aes_pkg::inv_sub_shift(r_s);
        n_s = r_s;
        if (i_cmd.load) begin
            n_s = {i_block_hi, i_block_lo};
        end else begin
            unique case (i_cmd.op)
                aes_pkg::OP_INIT: n_s = r_s ^ i_rk;
                aes_pkg::OP_MID:  n_s = i_cmd.dec ? aes_pkg::inv_mix(is ^ i_rk)
                                                  : aes_pkg::fwd_mix(fs) ^ i_rk;
                aes_pkg::OP_LAST: n_s = (i_cmd.dec ? is : fs) ^ i_rk;
                default:          n_s = r_s;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        if (i_cmd.out_load) begin
            r_res <= r_s;
        end
    end

    assign o_result_hi = r_res[127:64];
    assign o_result_lo = r_res[63:0];

endmodule

@@ design/aes_ctrl.sv @@
// Controller state machine: request handshakes, key expansion and round sequencing.
module aes_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_action,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  aes_pkg::t_kx_stat          i_kx,
    output aes_pkg::t_kx_cmd           o_kx,
    output aes_pkg::t_dp_cmd           o_dp,
    output logic                       o_re,
    output logic [aes_pkg::ROW_AW-1:0] o_raddr
);

    aes_pkg::t_state r_state;
    aes_pkg::t_state n_state;
    logic [3:0]      r_rnd;
    logic [3:0]      n_rnd;
    logic            r_dec;
    logic            n_dec;
    logic            r_out_valid;
    logic            n_out_valid;
    logic [3:0]      nr;
    logic [3:0]      step;
    logic            in_acc;
    logic            cfg_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aes_pkg::ST_IDLE;
            r_rnd       <= '0;
            r_dec       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rnd       <= n_rnd;
            r_dec       <= n_dec;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        nr          = aes_pkg::num_rounds(i_kx.key_size);
        step        = r_rnd - 4'd1;
        o_in_ready  = r_state == aes_pkg::ST_IDLE;
        o_cfg_ready = r_state == aes_pkg::ST_IDLE && !i_in_valid;
        in_acc      = i_in_valid && o_in_ready;
        cfg_acc     = i_cfg_valid && o_cfg_ready;
        n_state     = r_state;
        n_rnd       = r_rnd;
        n_dec       = r_dec;
        n_out_valid = r_out_valid && !i_out_ready;
        o_kx.cfg_wr = cfg_acc;
        o_kx.start  = cfg_acc && i_kx.hit;
        o_dp.load     = 1'b0;
        o_dp.op       = aes_pkg::OP_NONE;
        o_dp.dec      = r_dec;
        o_dp.out_load = 1'b0;
        o_re        = 1'b0;
        o_raddr     = r_dec ? nr - r_rnd : r_rnd;
        unique case (r_state)
            aes_pkg::ST_IDLE: begin
                if (cfg_acc && i_kx.hit) begin
                    n_state = aes_pkg::ST_EXPAND;
                end else if (in_acc) begin
                    o_dp.load = 1'b1;
                    n_dec     = i_action;
                    n_rnd     = '0;
                    n_state   = aes_pkg::ST_FETCH;
                end
            end
            aes_pkg::ST_EXPAND: begin
                if (i_kx.done) begin
                    n_state = aes_pkg::ST_IDLE;
                end
            end
            aes_pkg::ST_FETCH: begin
                o_re    = 1'b1;
                n_rnd   = 4'd1;
                n_state = aes_pkg::ST_ROUND;
            end
            aes_pkg::ST_ROUND: begin
                o_re = r_rnd <= nr;
                if (step == 4'd0) begin
                    o_dp.op = aes_pkg::OP_INIT;
                end else if (step == nr) begin
                    o_dp.op = aes_pkg::OP_LAST;
                end else begin
                    o_dp.op = aes_pkg::OP_MID;
                end
                if (step == nr) begin
                    n_state = aes_pkg::ST_FINISH;
                end else begin
                    n_rnd = r_rnd + 4'd1;
                end
            end
            aes_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_dp.out_load = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = aes_pkg::ST_IDLE;
                end
            end
            default: n_state = aes_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_done_in_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_kx.done |-> r_state == aes_pkg::ST_EXPAND)
        else $error("key expansion finished outside the expand state");
    a_rise_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == aes_pkg::ST_FINISH)
        else $error("result became valid without a finished block");
    a_round_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == aes_pkg::ST_ROUND |-> r_rnd != 4'd0 && step <= nr)
        else $error("round counter out of range");
    a_no_item_while_expanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_kx.busy |-> !o_in_ready)
        else $error("input ready while key schedule is being expanded");
`endif

endmodule

@@ design/aes_block_cipher.sv @@
// AES-128/192/256 ECB block cipher top level.
// Each request carries one 128-bit block and a direction and yields one 128-bit result.
// A block runs one round per cycle on a shared round datapath, after a fetch state
// for the registered round-key RAM read; the result register is loaded in a finish state
// that waits while an earlier result is still unaccepted, and the next request is taken
// as soon as a result is in the output register. Any accepted register write except an
// out-of-range index or a key-size code above 2 re-expands the key schedule, one word
// per cycle, and no block is accepted while the expansion runs.
module aes_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [63:0] i_block_hi,
    input  logic [63:0] i_block_lo,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_result_hi,
    output logic [63:0] o_result_lo,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    aes_pkg::t_kx_cmd              kx_cmd;
    aes_pkg::t_kx_stat             kx_stat;
    aes_pkg::t_dp_cmd              dp_cmd;
    logic                          we;
    logic [aes_pkg::ROW_AW-1:0]    waddr;
    logic [127:0]                  wdata;
    logic                          re;
    logic [aes_pkg::ROW_AW-1:0]    raddr;
    logic [127:0]                  rk;

    aes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_kx        (kx_stat),
        .o_kx        (kx_cmd),
        .o_dp        (dp_cmd),
        .o_re        (re),
        .o_raddr     (raddr)
    );

    aes_keyexp u_keyexp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (kx_cmd),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (kx_stat),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata)
    );

    aes_ram #(
        .WIDTH (128),
        .DEPTH (aes_pkg::NUM_ROWS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rk)
    );

    aes_datapath u_dp (
        .i_clk       (i_clk),
        .i_cmd       (dp_cmd),
        .i_block_hi  (i_block_hi),
        .i_block_lo  (i_block_lo),
        .i_rk        (rk),
        .o_result_hi (o_result_hi),
        .o_result_lo (o_result_lo)
    );

endmodule
